// ===== hdl/can_telemetry_signal_decoder_macros.svh =====
// Assertion helpers for the telemetry decoder.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef CAN_TELEMETRY_SIGNAL_DECODER_MACROS_SVH
`define CAN_TELEMETRY_SIGNAL_DECODER_MACROS_SVH

// Same-cycle implication.
`define CTSD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ctsd assertion failed");

// Next-cycle implication.
`define CTSD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ctsd assertion failed");

`endif

// ===== hdl/ctsd_pkg.sv =====
package ctsd_pkg;

   localparam logic [28:0] ID_STATUS  = 29'h0201FF05;
   localparam logic [28:0] ID_HOURS   = 29'h0201FF13;
   localparam logic [28:0] ID_PHASE_A = 29'h0201F320;
   localparam logic [28:0] ID_PHASE_B = 29'h0201FF20;
   localparam logic [28:0] ID_TIMER   = 29'h0201FF14;

   localparam int unsigned STOP_BIT       = 6;
   localparam logic [7:0]  COOL_MODE      = 8'h2C;
   localparam int unsigned COOL_START_BIT = 4;
   localparam logic [9:0]  FUEL_MAX       = 10'd1000;

   // Configuration register indexes
   localparam logic [2:0] CSR_MAPPING_ENABLED = 3'd0;
   localparam logic [2:0] CSR_FUEL_FRAME_ID   = 3'd1;
   localparam logic [2:0] CSR_FUEL_FRAME_EXT  = 3'd2;
   localparam logic [2:0] CSR_FUEL_FIRST_BYTE = 3'd3;
   localparam logic [2:0] CSR_FUEL_WIDTH      = 3'd4;
   localparam logic [2:0] CSR_FUEL_LITTLE_END = 3'd5;
   localparam logic [2:0] CSR_FUEL_MULT       = 3'd6;
   localparam logic [2:0] CSR_FUEL_DIV        = 3'd7;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 29;

   localparam int unsigned DIV_STEPS = 32;
   localparam int unsigned DIV_CNT_W = 5;

   typedef struct packed {
      logic        mapping_enabled;
      logic [28:0] fuel_frame_id;
      logic        fuel_frame_extended;
      logic [2:0]  fuel_first_byte;
      logic [1:0]  fuel_width_bytes;
      logic        fuel_little_endian;
      logic [15:0] fuel_scale_multiplier;
      logic [15:0] fuel_scale_divisor;
   } cfg_type;

   typedef struct packed {
      logic [28:0] frame_ident;
      logic        is_extended;
      logic [3:0]  data_length;
      logic [63:0] payload;
   } req_item_type;

   typedef struct packed {
      logic [5:0]  valid_mask;
      logic [9:0]  fuel_permille;
      logic [7:0]  battery_decivolts;
      logic [23:0] run_minutes;
      logic [15:0] engine_speed;
      logic        operating;
      logic        cool_down;
      logic [7:0]  cool_timer;
   } rsp_item_type;

   typedef struct packed {
      logic capture;
      logic mul;
      logic div_step;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic fuel_pend;
   } dp_status_type;

endpackage

// ===== hdl/ctsd_interfaces.sv =====
interface ctsd_req_if;
   logic        valid;
   logic        ready;
   logic [28:0] frame_ident;
   logic        is_extended;
   logic [3:0]  data_length;
   logic [63:0] payload;

   modport source (output valid, frame_ident, is_extended, data_length, payload,
                   input ready);
   modport sink (input valid, frame_ident, is_extended, data_length, payload,
                 output ready);
endinterface

interface ctsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  valid_mask;
   logic [9:0]  fuel_permille;
   logic [7:0]  battery_decivolts;
   logic [23:0] run_minutes;
   logic [15:0] engine_speed;
   logic        operating;
   logic        cool_down;
   logic [7:0]  cool_timer;

   modport source (output valid, valid_mask, fuel_permille, battery_decivolts,
                   run_minutes, engine_speed, operating, cool_down, cool_timer,
                   input ready);
   modport sink (input valid, valid_mask, fuel_permille, battery_decivolts,
                 run_minutes, engine_speed, operating, cool_down, cool_timer,
                 output ready);
endinterface

// ===== hdl/ctsd_ctrl.sv =====
module ctsd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  ctsd_pkg::dp_status_type status,
   output ctsd_pkg::dp_cmd_type    cmd
);
   import ctsd_pkg::*;
   `include "can_telemetry_signal_decoder_macros.svh"

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_FIN  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul = 1'b1;
            if (status.fuel_pend) begin
               cnt_in   = DIV_CNT_W'(DIV_STEPS - 1);
               state_in = S_DIV;
            end else begin
               state_in = S_FIN;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   `CTSD_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0({cmd.capture, cmd.mul, cmd.div_step, cmd.finish}))
   `CTSD_ASSERT_NOW(a_no_overlap, 1'b1, !(req_ready && rsp_valid))
   `CTSD_ASSERT_NEXT(a_capture_mul, cmd.capture, cmd.mul)
   `CTSD_ASSERT_NEXT(a_div_done, cmd.div_step && cnt_ff == '0, cmd.finish)
   `CTSD_ASSERT_NEXT(a_finish_out, cmd.finish, rsp_valid)

endmodule

// ===== hdl/ctsd_dp.sv =====
module ctsd_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [ctsd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ctsd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  ctsd_pkg::req_item_type           req_item,
   input  ctsd_pkg::dp_cmd_type             cmd,
   output ctsd_pkg::dp_status_type          status,
   output ctsd_pkg::rsp_item_type           rsp_item
);
   import ctsd_pkg::*;

   cfg_type cfg_ff;

   logic        latch_ff;
   logic [5:0]  mask_ff;
   logic [7:0]  batt_ff;
   logic [23:0] mins_ff;
   logic [15:0] rpm_ff;
   logic        oper_ff;
   logic [7:0]  timer_ff;
   logic        fuel_pend_ff;
   logic [15:0] raw_ff;
   logic [31:0] quo_ff;
   logic [16:0] rem_ff;
   logic [9:0]  fuel_ff;

   logic [5:0]  mask_in;
   logic [7:0]  batt_in;
   logic [23:0] mins_in;
   logic [15:0] rpm_in;
   logic        oper_in;
   logic [7:0]  timer_in;
   logic        fuel_pend_in;
   logic [15:0] raw_in;
   logic        latch_in;

   logic [7:0]  byte0, byte1, byte2, byte4, byte6, byte7;
   logic [7:0]  fb0, fb1;
   logic [2:0]  fsec;
   logic [3:0]  fcnt, fend;
   logic        phase, known, fuel_sel;
   logic [28:0] id;
   logic [3:0]  len;

   logic [16:0] rem_sh;
   logic [16:0] rem_sub;
   logic        take;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mapping_enabled       <= 1'b1;
         cfg_ff.fuel_frame_id         <= ID_STATUS;
         cfg_ff.fuel_frame_extended   <= 1'b1;
         cfg_ff.fuel_first_byte       <= 3'd0;
         cfg_ff.fuel_width_bytes      <= 2'd2;
         cfg_ff.fuel_little_endian    <= 1'b1;
         cfg_ff.fuel_scale_multiplier <= 16'd1;
         cfg_ff.fuel_scale_divisor    <= 16'd1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MAPPING_ENABLED: cfg_ff.mapping_enabled       <= csr_wdata[0];
            CSR_FUEL_FRAME_ID:   cfg_ff.fuel_frame_id         <= csr_wdata[28:0];
            CSR_FUEL_FRAME_EXT:  cfg_ff.fuel_frame_extended   <= csr_wdata[0];
            CSR_FUEL_FIRST_BYTE: cfg_ff.fuel_first_byte       <= csr_wdata[2:0];
            CSR_FUEL_WIDTH:      cfg_ff.fuel_width_bytes      <= csr_wdata[1:0];
            CSR_FUEL_LITTLE_END: cfg_ff.fuel_little_endian    <= csr_wdata[0];
            CSR_FUEL_MULT:       cfg_ff.fuel_scale_multiplier <= csr_wdata[15:0];
            CSR_FUEL_DIV:        cfg_ff.fuel_scale_divisor    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Frame decode
   always_comb begin
      id    = req_item.frame_ident;
      len   = req_item.data_length;
      byte0 = req_item.payload[7:0];
      byte1 = req_item.payload[15:8];
      byte2 = req_item.payload[23:16];
      byte4 = req_item.payload[39:32];
      byte6 = req_item.payload[55:48];
      byte7 = req_item.payload[63:56];

      phase = (id == ID_PHASE_A) || (id == ID_PHASE_B);
      known = req_item.is_extended &&
              ((id == ID_STATUS) || (id == ID_HOURS) || phase || (id == ID_TIMER));

      fcnt = (cfg_ff.fuel_width_bytes == 2'd1) ? 4'd1 : 4'd2;
      fend = {1'b0, cfg_ff.fuel_first_byte} + fcnt;
      fsec = cfg_ff.fuel_first_byte + 3'd1;
      fb0  = req_item.payload[{cfg_ff.fuel_first_byte, 3'b000} +: 8];
      fb1  = req_item.payload[{fsec, 3'b000} +: 8];

      fuel_sel = known && cfg_ff.mapping_enabled && (id == cfg_ff.fuel_frame_id) &&
                 (req_item.is_extended == cfg_ff.fuel_frame_extended);
      fuel_pend_in = fuel_sel && (fend <= 4'd8) && (len >= fend) &&
                     (cfg_ff.fuel_scale_divisor != 16'd0);
      if (fcnt == 4'd1) begin
         raw_in = {8'd0, fb0};
      end else if (cfg_ff.fuel_little_endian) begin
         raw_in = {fb1, fb0};
      end else begin
         raw_in = {fb0, fb1};
      end

      mask_in  = '0;
      batt_in  = '0;
      mins_in  = '0;
      rpm_in   = '0;
      oper_in  = 1'b0;
      timer_in = '0;
      latch_in = latch_ff;

      mask_in[0] = fuel_pend_in;
      if (known && (id == ID_STATUS) && (len > 4'd4)) begin
         batt_in    = byte4;
         mask_in[1] = 1'b1;
      end
      if (known && (id == ID_HOURS) && (len >= 4'd3)) begin
         mins_in    = {byte2, byte1, byte0};
         mask_in[2] = 1'b1;
      end
      if (known && (id == ID_STATUS) && (len >= 4'd8)) begin
         rpm_in     = {byte7, byte6};
         mask_in[3] = 1'b1;
      end
      if (known && phase && (len >= 4'd1)) begin
         oper_in    = !byte0[STOP_BIT];
         mask_in[4] = 1'b1;
      end
      if (known && phase && (len >= 4'd3)) begin
         if (byte0[STOP_BIT]) begin
            latch_in = 1'b0;
         end else if ((byte1 == COOL_MODE) && !byte2[COOL_START_BIT]) begin
            latch_in = 1'b1;
         end
      end
      if (known && (id == ID_TIMER) && (len > 4'd4)) begin
         timer_in   = byte4;
         mask_in[5] = 1'b1;
      end
   end

   // One restoring division step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      rem_sh  = {rem_ff[15:0], quo_ff[31]};
      take    = rem_sh >= {1'b0, cfg_ff.fuel_scale_divisor};
      rem_sub = rem_sh - {1'b0, cfg_ff.fuel_scale_divisor};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff <= 1'b0;
      end else if (cmd.capture) begin
         latch_ff <= latch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mask_ff      <= mask_in;
         batt_ff      <= batt_in;
         mins_ff      <= mins_in;
         rpm_ff       <= rpm_in;
         oper_ff      <= oper_in;
         timer_ff     <= timer_in;
         fuel_pend_ff <= fuel_pend_in;
         raw_ff       <= raw_in;
      end
      if (cmd.mul) begin
         quo_ff <= {16'd0, raw_ff} * {16'd0, cfg_ff.fuel_scale_multiplier};
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[30:0], take};
         rem_ff <= take ? rem_sub : rem_sh;
      end
      if (cmd.finish) begin
         // clamp to full scale
         if (!fuel_pend_ff) begin
            fuel_ff <= '0;
         end else if (quo_ff > {22'd0, FUEL_MAX}) begin
            fuel_ff <= FUEL_MAX;
         end else begin
            fuel_ff <= quo_ff[9:0];
         end
      end
   end

   assign status.fuel_pend = fuel_pend_ff;

   assign rsp_item.valid_mask        = mask_ff;
   assign rsp_item.fuel_permille     = fuel_ff;
   assign rsp_item.battery_decivolts = batt_ff;
   assign rsp_item.run_minutes       = mins_ff;
   assign rsp_item.engine_speed      = rpm_ff;
   assign rsp_item.operating         = oper_ff;
   assign rsp_item.cool_down         = latch_ff;
   assign rsp_item.cool_timer        = timer_ff;

endmodule

// ===== hdl/can_telemetry_signal_decoder.sv =====
// CAN telemetry signal decoder.
// req_chan carries one received frame (identifier, extended flag, length and
// eight payload bytes); rsp_chan returns exactly one result per frame with a
// valid mask and the decoded fuel, battery, run minutes, rpm, run state,
// cool-down latch and cool-down timer. The csr_ port writes the fuel mapping
// registers by index; write them only while no frame is in flight.
// Frames are handled one at a time. A frame that yields a fuel value runs
// the multiply state, the bit-serial restoring divider and the clamp state
// before the result is offered; the next frame is taken the cycle after the
// result transfer. Any other frame skips the divider.
// While rsp_chan is stalled the result holds and req_chan.ready stays low.
// Reset (synchronous, active high) clears the cool-down latch, restores the
// default fuel mapping and returns the controller to idle.
module can_telemetry_signal_decoder (
   input  logic                             clock,
   input  logic                             reset,
   ctsd_req_if.sink                         req_chan,
   ctsd_rsp_if.source                       rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [ctsd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ctsd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ctsd_pkg::*;

   req_item_type  req_item;
   rsp_item_type  rsp_item;
   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_ready;
   logic          rsp_valid;

   assign req_item.frame_ident = req_chan.frame_ident;
   assign req_item.is_extended = req_chan.is_extended;
   assign req_item.data_length = req_chan.data_length;
   assign req_item.payload     = req_chan.payload;
   assign req_chan.ready       = req_ready;

   ctsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ctsd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .rsp_item  (rsp_item)
   );

   assign rsp_chan.valid             = rsp_valid;
   assign rsp_chan.valid_mask        = rsp_item.valid_mask;
   assign rsp_chan.fuel_permille     = rsp_item.fuel_permille;
   assign rsp_chan.battery_decivolts = rsp_item.battery_decivolts;
   assign rsp_chan.run_minutes       = rsp_item.run_minutes;
   assign rsp_chan.engine_speed      = rsp_item.engine_speed;
   assign rsp_chan.operating         = rsp_item.operating;
   assign rsp_chan.cool_down         = rsp_item.cool_down;
   assign rsp_chan.cool_timer        = rsp_item.cool_timer;

endmodule

// ===== dv/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ctsd_pkg::*;

   localparam int unsigned CLK_PERIOD   = 8;
   localparam int unsigned RESET_CYCLES = 6;
   localparam int unsigned PHASES       = 20;
   localparam int unsigned CORNER_SETS  = 9;
   localparam int unsigned PHASE_FRAMES = 95;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned IDLE_PCT     = 26;

   localparam cfg_type DEFAULT_SETTINGS = '{
      mapping_enabled: 1'b1,
      fuel_frame_id: ID_STATUS,
      fuel_frame_extended: 1'b1,
      fuel_first_byte: 3'd0,
      fuel_width_bytes: 2'd2,
      fuel_little_endian: 1'b1,
      fuel_scale_multiplier: 16'd1,
      fuel_scale_divisor: 16'd1
   };

   class telemetry_scoreboard;
      cfg_type      settings;
      logic         cooling;
      rsp_item_type pending_decodes[$];
      int unsigned  failures;
      int unsigned  frames;
      int unsigned  results;
      int unsigned  latch_sets;
      int unsigned  field_hits[6];

      function new();
         settings = DEFAULT_SETTINGS;
         cooling  = 1'b0;
      endfunction

      function rsp_item_type decode_frame(req_item_type f);
         rsp_item_type r;
         logic [7:0]   b[8];
         logic         phase;
         logic         known;
         int unsigned  cnt;
         int unsigned  first;
         logic [31:0]  raw;
         logic [31:0]  level;
         r = '0;
         for (int k = 0; k < 8; k++)
            b[k] = f.payload[8*k +: 8];
         phase = (f.frame_ident == ID_PHASE_A) || (f.frame_ident == ID_PHASE_B);
         known = f.is_extended && (phase || f.frame_ident == ID_STATUS ||
                 f.frame_ident == ID_HOURS || f.frame_ident == ID_TIMER);
         if (known) begin
            if (settings.mapping_enabled && f.frame_ident == settings.fuel_frame_id &&
                f.is_extended == settings.fuel_frame_extended) begin
               cnt   = (settings.fuel_width_bytes == 2'd1) ? 1 : 2;
               first = 32'(settings.fuel_first_byte);
               if (first + cnt <= 8 && 32'(f.data_length) >= first + cnt &&
                   settings.fuel_scale_divisor != 16'd0) begin
                  if (cnt == 1)
                     raw = {24'd0, b[first]};
                  else if (settings.fuel_little_endian)
                     raw = {16'd0, b[first+1], b[first]};
                  else
                     raw = {16'd0, b[first], b[first+1]};
                  level = (raw * {16'd0, settings.fuel_scale_multiplier}) /
                          {16'd0, settings.fuel_scale_divisor};
                  if (level > 32'(FUEL_MAX))
                     level = 32'(FUEL_MAX);
                  r.fuel_permille = level[9:0];
                  r.valid_mask[0] = 1'b1;
               end
            end
            if (f.frame_ident == ID_STATUS && f.data_length > 4) begin
               r.battery_decivolts = b[4];
               r.valid_mask[1] = 1'b1;
            end
            if (f.frame_ident == ID_HOURS && f.data_length >= 3) begin
               r.run_minutes = {b[2], b[1], b[0]};
               r.valid_mask[2] = 1'b1;
            end
            if (f.frame_ident == ID_STATUS && f.data_length >= 8) begin
               r.engine_speed = {b[7], b[6]};
               r.valid_mask[3] = 1'b1;
            end
            if (phase && f.data_length >= 1) begin
               r.operating = !b[0][STOP_BIT];
               r.valid_mask[4] = 1'b1;
            end
            // stop wins over a cool-down start in the same frame
            if (phase && f.data_length >= 3) begin
               if (b[0][STOP_BIT])
                  cooling = 1'b0;
               else if (b[1] == COOL_MODE && !b[2][COOL_START_BIT]) begin
                  if (!cooling)
                     latch_sets++;
                  cooling = 1'b1;
               end
            end
            if (f.frame_ident == ID_TIMER && f.data_length > 4) begin
               r.cool_timer = b[4];
               r.valid_mask[5] = 1'b1;
            end
         end
         r.cool_down = cooling;
         return r;
      endfunction

      function void note_frame(req_item_type f);
         pending_decodes.push_back(decode_frame(f));
         frames++;
      endfunction

      function void compare_field(string label, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         end
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (pending_decodes.size() == 0) begin
            failures++;
            $display("%0t: result with nothing outstanding, expected none, actual %h",
                     $time, got);
            return;
         end
         want = pending_decodes.pop_front();
         results++;
         for (int k = 0; k < 6; k++)
            if (want.valid_mask[k])
               field_hits[k]++;
         compare_field("valid_mask", 32'(want.valid_mask), 32'(got.valid_mask));
         compare_field("fuel_permille", 32'(want.fuel_permille), 32'(got.fuel_permille));
         compare_field("battery_decivolts", 32'(want.battery_decivolts),
                       32'(got.battery_decivolts));
         compare_field("run_minutes", 32'(want.run_minutes), 32'(got.run_minutes));
         compare_field("engine_speed", 32'(want.engine_speed), 32'(got.engine_speed));
         compare_field("operating", 32'(want.operating), 32'(got.operating));
         compare_field("cool_down", 32'(want.cool_down), 32'(got.cool_down));
         compare_field("cool_timer", 32'(want.cool_timer), 32'(got.cool_timer));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   ctsd_req_if req_chan();
   ctsd_rsp_if rsp_chan();

   telemetry_scoreboard sb = new();
   bit steady;
   bit hold_request;

   can_telemetry_signal_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_result({rsp_chan.valid_mask, rsp_chan.fuel_permille,
                             rsp_chan.battery_decivolts, rsp_chan.run_minutes,
                             rsp_chan.engine_speed, rsp_chan.operating,
                             rsp_chan.cool_down, rsp_chan.cool_timer});
         if (req_chan.valid && req_chan.ready)
            sb.note_frame({req_chan.frame_ident, req_chan.is_extended,
                           req_chan.data_length, req_chan.payload});
      end
   end

   // Result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_chan.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic req_item_type make_frame(logic [28:0] ident, logic ext,
                                                logic [3:0] len, logic [63:0] data);
      req_item_type f;
      f.frame_ident = ident;
      f.is_extended = ext;
      f.data_length = len;
      f.payload     = data;
      return f;
   endfunction

   function automatic req_item_type random_frame();
      req_item_type f;
      logic [28:0]  ids[5] = '{ID_STATUS, ID_HOURS, ID_PHASE_A, ID_PHASE_B, ID_TIMER};
      int unsigned  pick;
      pick = $urandom_range(99);
      if (pick < 60)
         f.frame_ident = ids[$urandom_range(4)];
      else if (pick < 80)
         f.frame_ident = sb.settings.fuel_frame_id;
      else if (pick < 90)
         f.frame_ident = 29'($urandom_range(11'h7FF));
      else
         f.frame_ident = 29'($urandom);
      f.is_extended = ($urandom_range(99) < 90);
      f.data_length = ($urandom_range(99) < 85) ? 4'($urandom_range(8))
                                                 : 4'($urandom_range(15));
      f.payload = {$urandom, $urandom};
      // keep raw fuel values modest now and then so scaling does not always clamp
      if ($urandom_range(99) < 30)
         f.payload &= 64'h0303_0303_0303_0303;
      if ((f.frame_ident == ID_PHASE_A || f.frame_ident == ID_PHASE_B) &&
          $urandom_range(99) < 60) begin
         f.payload[15:8] = COOL_MODE;
         f.payload[STOP_BIT] = ($urandom_range(99) < 30);
         f.payload[16 + COOL_START_BIT] = ($urandom_range(99) < 30);
      end
      return f;
   endfunction

   function automatic cfg_type corner_settings(int unsigned idx);
      cfg_type c;
      c = DEFAULT_SETTINGS;
      case (idx)
         0: c.mapping_enabled = 1'b0;
         1: begin
            c.fuel_frame_id = ID_HOURS;
            c.fuel_first_byte = 3'd7;
            c.fuel_width_bytes = 2'd1;
            c.fuel_scale_multiplier = 16'hFFFF;
            c.fuel_scale_divisor = 16'hFFFF;
         end
         2: begin
            c.fuel_frame_id = ID_TIMER;
            c.fuel_first_byte = 3'd6;
            c.fuel_little_endian = 1'b0;
            c.fuel_scale_multiplier = 16'd0;
         end
         3: begin
            c.fuel_frame_id = ID_PHASE_A;
            c.fuel_first_byte = 3'd7;
            c.fuel_width_bytes = 2'd2;
         end
         4: c.fuel_scale_divisor = 16'd0;
         5: c.fuel_frame_extended = 1'b0;
         6: begin
            c.fuel_frame_id = 29'h1FFF_FFFF;
            c.fuel_width_bytes = 2'd0;
         end
         7: begin
            c.fuel_frame_id = ID_PHASE_B;
            c.fuel_first_byte = 3'd3;
            c.fuel_width_bytes = 2'd3;
            c.fuel_little_endian = 1'b0;
            c.fuel_scale_multiplier = 16'd3;
            c.fuel_scale_divisor = 16'd200;
         end
         default: begin
            c.fuel_width_bytes = 2'd1;
            c.fuel_scale_multiplier = 16'd4;
         end
      endcase
      return c;
   endfunction

   function automatic cfg_type random_settings();
      cfg_type     c;
      logic [28:0] ids[5] = '{ID_STATUS, ID_HOURS, ID_PHASE_A, ID_PHASE_B, ID_TIMER};
      int unsigned pick;
      c.mapping_enabled = ($urandom_range(99) < 85);
      c.fuel_frame_id = ($urandom_range(99) < 80) ? ids[$urandom_range(4)]
                                                   : 29'($urandom);
      c.fuel_frame_extended = ($urandom_range(99) < 90);
      c.fuel_first_byte = 3'($urandom_range(7));
      c.fuel_width_bytes = 2'($urandom_range(3));
      c.fuel_little_endian = 1'($urandom_range(1));
      c.fuel_scale_multiplier = ($urandom_range(99) < 30) ? 16'($urandom)
                                                           : 16'($urandom_range(64));
      pick = $urandom_range(99);
      if (pick < 5)
         c.fuel_scale_divisor = 16'd0;
      else if (pick < 35)
         c.fuel_scale_divisor = 16'($urandom_range(16'hFFFF, 1));
      else
         c.fuel_scale_divisor = 16'($urandom_range(255, 1));
      return c;
   endfunction

   // Called at a rising edge; keeps valid high across back-to-back frames
   task automatic send_frame(input req_item_type f);
      if (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 50);
      end
      req_chan.valid       <= 1'b1;
      req_chan.frame_ident <= f.frame_ident;
      req_chan.is_extended <= f.is_extended;
      req_chan.data_length <= f.data_length;
      req_chan.payload     <= f.payload;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_decodes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(input cfg_type c);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MAPPING_ENABLED;
      csr_wdata <= CSR_DATA_W'(c.mapping_enabled);
      @(posedge clock);
      csr_index <= CSR_FUEL_FRAME_ID;
      csr_wdata <= CSR_DATA_W'(c.fuel_frame_id);
      @(posedge clock);
      csr_index <= CSR_FUEL_FRAME_EXT;
      csr_wdata <= CSR_DATA_W'(c.fuel_frame_extended);
      @(posedge clock);
      csr_index <= CSR_FUEL_FIRST_BYTE;
      csr_wdata <= CSR_DATA_W'(c.fuel_first_byte);
      @(posedge clock);
      csr_index <= CSR_FUEL_WIDTH;
      csr_wdata <= CSR_DATA_W'(c.fuel_width_bytes);
      @(posedge clock);
      csr_index <= CSR_FUEL_LITTLE_END;
      csr_wdata <= CSR_DATA_W'(c.fuel_little_endian);
      @(posedge clock);
      csr_index <= CSR_FUEL_MULT;
      csr_wdata <= CSR_DATA_W'(c.fuel_scale_multiplier);
      @(posedge clock);
      csr_index <= CSR_FUEL_DIV;
      csr_wdata <= CSR_DATA_W'(c.fuel_scale_divisor);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.settings = c;
   endtask

   initial begin
      req_item_type directed[$];
      reset                <= 1'b1;
      csr_wr_en            <= 1'b0;
      csr_index            <= '0;
      csr_wdata            <= '0;
      req_chan.valid       <= 1'b0;
      req_chan.frame_ident <= '0;
      req_chan.is_extended <= 1'b0;
      req_chan.data_length <= '0;
      req_chan.payload     <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default mapping: fuel from the status frame, bytes 0 and 1, unscaled
      directed.push_back(make_frame(ID_STATUS, 1'b1, 4'd8, 64'h3412_00C8_0000_03E8));
      directed.push_back(make_frame(ID_STATUS, 1'b1, 4'd4, 64'h3412_00C8_0000_0123));
      directed.push_back(make_frame(ID_STATUS, 1'b1, 4'd5, 64'h3412_00C8_0000_0000));
      directed.push_back(make_frame(ID_STATUS, 1'b1, 4'd15, '1));
      directed.push_back(make_frame(ID_STATUS, 1'b1, 4'd0, '1));
      directed.push_back(make_frame(ID_STATUS, 1'b1, 4'd1, '1));
      directed.push_back(make_frame(ID_STATUS, 1'b0, 4'd8, '1));
      directed.push_back(make_frame(ID_HOURS, 1'b1, 4'd3, 64'hFFFF_FFFF_FFFF_FFFF));
      directed.push_back(make_frame(ID_HOURS, 1'b1, 4'd2, 64'h0000_0000_0012_3456));
      directed.push_back(make_frame(ID_PHASE_A, 1'b1, 4'd3, 64'h0000_2C00));
      directed.push_back(make_frame(ID_PHASE_B, 1'b1, 4'd3, 64'h0010_2C00));
      directed.push_back(make_frame(ID_PHASE_B, 1'b1, 4'd1, 64'h0000_0040));
      directed.push_back(make_frame(ID_PHASE_A, 1'b1, 4'd8, 64'h0000_0040));
      directed.push_back(make_frame(ID_PHASE_B, 1'b1, 4'd2, 64'h0000_2C00));
      directed.push_back(make_frame(ID_PHASE_A, 1'b1, 4'd3, 64'h0000_2C00));
      directed.push_back(make_frame(ID_PHASE_A, 1'b1, 4'd3, 64'h0000_2C40));
      directed.push_back(make_frame(ID_PHASE_B, 1'b1, 4'd0, 64'h0000_2C00));
      directed.push_back(make_frame(ID_TIMER, 1'b1, 4'd5, 64'h0000_00B4_0000_0000));
      directed.push_back(make_frame(ID_TIMER, 1'b1, 4'd4, 64'h0000_00B4_0000_0000));
      directed.push_back(make_frame(29'h1FFF_FFFF, 1'b1, 4'd8, '1));
      directed.push_back(make_frame(29'd0, 1'b0, 4'd0, '0));
      directed.push_back(make_frame(ID_STATUS, 1'b1, 4'd8, '0));
      foreach (directed[i])
         send_frame(directed[i]);

      for (int unsigned phase_idx = 0; phase_idx < PHASES; phase_idx++) begin
         drain();
         apply_settings(phase_idx < CORNER_SETS ? corner_settings(phase_idx)
                                                : random_settings());
         steady = (phase_idx == 12);
         for (int unsigned n = 0; n < PHASE_FRAMES; n++) begin
            // stall results for a long stretch while frames keep coming
            if (phase_idx == 3 && n == 10)
               hold_request = 1'b1;
            send_frame(random_frame());
         end
      end
      steady = 1'b0;
      drain();
      repeat (50) @(posedge clock);

      $display("Run covered %0d frames and %0d results over %0d register settings, %0d %s",
               sb.frames, sb.results, PHASES + 1, sb.latch_sets, "cool-down starts.");
      $display("Decoded fuel %0d, battery %0d, minutes %0d, rpm %0d, run state %0d, %s%0d",
               sb.field_hits[0], sb.field_hits[1], sb.field_hits[2], sb.field_hits[3],
               sb.field_hits[4], "timer ", sb.field_hits[5]);
      if (sb.failures == 0 && sb.pending_decodes.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ctsd_pkg.sv
hdl/ctsd_interfaces.sv
hdl/ctsd_ctrl.sv
hdl/ctsd_dp.sv
hdl/can_telemetry_signal_decoder.sv
dv/testbench.sv
